// ===== rtl/core/exact_double_stream_sum_top_macros.svh =====
// Assertion macros for the exact double stream sum block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef EXACT_DOUBLE_STREAM_SUM_TOP_MACROS_SVH
`define EXACT_DOUBLE_STREAM_SUM_TOP_MACROS_SVH

// same-cycle implication
`define EDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/eds_pkg.sv =====
// Shared types, constants and helpers for the exact double stream sum.
// No dependencies.
`timescale 1ns / 1ps

package eds_pkg;

    localparam int MAX_PARTIALS = 64;
    localparam int PIDX_W       = $clog2(MAX_PARTIALS);
    localparam int PCNT_W       = $clog2(MAX_PARTIALS + 1);
    localparam logic [PCNT_W-1:0] MAX_CNT = PCNT_W'(MAX_PARTIALS);

    localparam logic [63:0] QNAN_BITS  = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DNAN_BITS  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] PINF_BITS  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] MINF_BITS  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] MZERO_BITS = 64'h8000_0000_0000_0000;
    localparam logic [63:0] PZERO_BITS = 64'h0000_0000_0000_0000;

    typedef enum logic [2:0] {
        MODE_MZERO  = 3'd0,
        MODE_FINITE = 3'd1,
        MODE_PINF   = 3'd2,
        MODE_MINF   = 3'd3,
        MODE_NAN    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ALIGN,
        A_ADD,
        A_NORM,
        A_ROUND
    } add_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_RD,
        S_LD,
        S_HI,
        S_T,
        S_LO,
        S_TAIL,
        S_TLD,
        S_TADD,
        S_FIN,
        S_FRD,
        S_FLD,
        S_FADD,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        sub;
    } dadd_req_t;

    typedef struct packed {
        logic              idle;
        logic [PCNT_W-1:0] cnt;
    } seq_stat_t;

    function automatic logic is_nan(input logic [63:0] v);
        is_nan = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] v);
        is_inf = (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] v);
        is_zero = (v[62:0] == 63'd0);
    endfunction

endpackage

// ===== rtl/core/exact_double_stream_sum_top.sv =====
// Exact streaming sum of binary64 values with a store of non-overlapping partials.
// Each finite nonzero element merges with every stored partial using three passes of
// the one shared adder, whose normalize step runs in 16/4/1-bit shifts.
// A full store adds one more pass. The closing beat sums the partials, one pass each
// (none when the mode is not finite), then waits on out_ready; one beat in flight at a time.
// Reset (async, active low) clears mode and partial count; partial RAM is not cleared.
`timescale 1ns / 1ps
`include "exact_double_stream_sum_top_macros.svh"

module exact_double_stream_sum_top
    import eds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value_bits,
    input  logic        has_value,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] sum_bits
);

    logic              add_start;
    dadd_req_t         add_req;
    logic              add_busy;
    logic              add_done;
    logic [63:0]       add_res;
    logic              ram_we;
    logic [PIDX_W-1:0] ram_waddr;
    logic [63:0]       ram_wdata;
    logic [PIDX_W-1:0] ram_raddr;
    logic [63:0]       ram_rdata;
    seq_stat_t         stat;

    eds_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_bits (value_bits),
        .has_value  (has_value),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sum_bits   (sum_bits),
        .add_start  (add_start),
        .add_req    (add_req),
        .add_done   (add_done),
        .add_res    (add_res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .stat       (stat)
    );

    eds_dadd u_dadd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (add_start),
        .req    (add_req),
        .busy   (add_busy),
        .done   (add_done),
        .result (add_res)
    );

    eds_ram #(
        .WIDTH (64),
        .DEPTH (MAX_PARTIALS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `EDS_ASSERT_NOW(a_add_start_idle, add_start, !add_busy && !add_done, "adder started while busy")
    `EDS_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "input taken while working")
    `EDS_ASSERT_NOW(a_cnt_bound, stat.idle, stat.cnt <= MAX_CNT, "partial count over capacity")
    `EDS_ASSERT_NOW(a_cnt_clear, $rose(out_valid), stat.cnt == '0, "state not cleared on result")

endmodule

// ===== rtl/core/eds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module eds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/eds_dadd.sv =====
// Multi-cycle binary64 adder/subtractor, round to nearest even.
// Depends on eds_pkg.
`timescale 1ns / 1ps

module eds_dadd
    import eds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  dadd_req_t   req,
    output logic        busy,
    output logic        done,
    output logic [63:0] result
);

    add_state_t  st_reg, st_next;
    logic        sgn_reg, sgn_next;
    logic        esub_reg, esub_next;
    logic [11:0] exp_reg, exp_next;
    logic [55:0] ml_reg, ml_next;
    logic [55:0] ms_reg, ms_next;
    logic [10:0] sh_reg, sh_next;
    logic [56:0] m_reg, m_next;
    logic [63:0] res_reg, res_next;
    logic        done_reg, done_next;

    logic [63:0] a, be, big, lit;
    logic        swp;
    logic [10:0] eb, el;
    logic [55:0] mask;
    logic        stk;
    logic [52:0] keep;
    logic        up;
    logic [53:0] rnd;
    logic [11:0] re;
    logic [52:0] rm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= A_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sgn_reg  <= sgn_next;
        esub_reg <= esub_next;
        exp_reg  <= exp_next;
        ml_reg   <= ml_next;
        ms_reg   <= ms_next;
        sh_reg   <= sh_next;
        m_reg    <= m_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        sgn_next  = sgn_reg;
        esub_next = esub_reg;
        exp_next  = exp_reg;
        ml_next   = ml_reg;
        ms_next   = ms_reg;
        sh_next   = sh_reg;
        m_next    = m_reg;
        res_next  = res_reg;
        done_next = 1'b0;

        a   = req.a;
        be  = is_nan(req.b) ? req.b : {req.b[63] ^ req.sub, req.b[62:0]};
        swp = a[62:0] < be[62:0];
        big = swp ? be : a;
        lit = swp ? a : be;
        el  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        eb  = (lit[62:52] == 11'd0) ? 11'd1 : lit[62:52];

        mask = ~(56'hFF_FFFF_FFFF_FFFF << sh_reg[5:0]);
        stk  = |(ms_reg & mask);

        keep = m_reg[55:3];
        up   = m_reg[2] & (m_reg[1] | m_reg[0] | m_reg[3]);
        rnd  = {1'b0, keep} + {53'd0, up};
        re   = rnd[53] ? exp_reg + 12'd1 : exp_reg;
        rm   = rnd[53] ? rnd[53:1] : rnd[52:0];

        case (st_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    if (is_nan(a))
                    begin
                        res_next  = a | QNAN_BITS;
                        done_next = 1'b1;
                    end
                    else if (is_nan(be))
                    begin
                        res_next  = be | QNAN_BITS;
                        done_next = 1'b1;
                    end
                    else if (is_inf(a) && is_inf(be) && (a[63] != be[63]))
                    begin
                        res_next  = DNAN_BITS;
                        done_next = 1'b1;
                    end
                    else if (is_inf(a))
                    begin
                        res_next  = a;
                        done_next = 1'b1;
                    end
                    else if (is_inf(be))
                    begin
                        res_next  = be;
                        done_next = 1'b1;
                    end
                    else if (is_zero(a) && is_zero(be))
                    begin
                        res_next  = {a[63] & be[63], 63'd0};
                        done_next = 1'b1;
                    end
                    else if (is_zero(a))
                    begin
                        res_next  = be;
                        done_next = 1'b1;
                    end
                    else if (is_zero(be))
                    begin
                        res_next  = a;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        sgn_next  = big[63];
                        esub_next = a[63] ^ be[63];
                        exp_next  = {1'b0, el};
                        ml_next   = {big[62:52] != 11'd0, big[51:0], 3'b000};
                        ms_next   = {lit[62:52] != 11'd0, lit[51:0], 3'b000};
                        sh_next   = el - eb;
                        st_next   = A_ALIGN;
                    end
                end
            end
            A_ALIGN:
            begin
                // keep shifted-out bits as sticky in the lsb
                if (sh_reg >= 11'd56)
                begin
                    ms_next = {55'd0, |ms_reg};
                end
                else
                begin
                    ms_next = (ms_reg >> sh_reg[5:0]) | {55'd0, stk};
                end
                st_next = A_ADD;
            end
            A_ADD:
            begin
                if (esub_reg)
                begin
                    m_next = {1'b0, ml_reg - ms_reg};
                end
                else
                begin
                    m_next = {1'b0, ml_reg} + {1'b0, ms_reg};
                end
                st_next = A_NORM;
            end
            A_NORM:
            begin
                if (m_reg == 57'd0)
                begin
                    res_next  = PZERO_BITS;
                    done_next = 1'b1;
                    st_next   = A_IDLE;
                end
                else if (m_reg[56])
                begin
                    m_next   = {1'b0, m_reg[56:2], m_reg[1] | m_reg[0]};
                    exp_next = exp_reg + 12'd1;
                    st_next  = A_ROUND;
                end
                else if (m_reg[55] || (exp_reg == 12'd1))
                begin
                    st_next = A_ROUND;
                end
                else if ((m_reg[55:40] == 16'd0) && (exp_reg > 12'd16))
                begin
                    m_next   = {1'b0, m_reg[39:0], 16'd0};
                    exp_next = exp_reg - 12'd16;
                end
                else if ((m_reg[55:52] == 4'd0) && (exp_reg > 12'd4))
                begin
                    m_next   = {1'b0, m_reg[51:0], 4'd0};
                    exp_next = exp_reg - 12'd4;
                end
                else
                begin
                    m_next   = {1'b0, m_reg[54:0], 1'b0};
                    exp_next = exp_reg - 12'd1;
                end
            end
            A_ROUND:
            begin
                if (re >= 12'd2047)
                begin
                    res_next = {sgn_reg, 11'h7FF, 52'd0};
                end
                else
                begin
                    res_next = {sgn_reg, rm[52] ? re[10:0] : 11'd0, rm[51:0]};
                end
                done_next = 1'b1;
                st_next   = A_IDLE;
            end
            default:
            begin
                st_next = A_IDLE;
            end
        endcase
    end

    assign busy   = (st_reg != A_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/core/eds_seq.sv =====
// Sequencer: input/output beats, mode tracking, partial merge and final sum.
// Depends on eds_pkg; drives the shared adder and the partial RAM.
`timescale 1ns / 1ps

module eds_seq
    import eds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       value_bits,
    input  logic              has_value,
    input  logic              is_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       sum_bits,
    output logic              add_start,
    output dadd_req_t         add_req,
    input  logic              add_done,
    input  logic [63:0]       add_res,
    output logic              ram_we,
    output logic [PIDX_W-1:0] ram_waddr,
    output logic [63:0]       ram_wdata,
    output logic [PIDX_W-1:0] ram_raddr,
    input  logic [63:0]       ram_rdata,
    output seq_stat_t         stat
);

    seq_state_t        st_reg, st_next;
    mode_t             mode_reg, mode_next;
    logic [PCNT_W-1:0] cnt_reg, cnt_next;
    logic [PCNT_W-1:0] kept_reg, kept_next;
    logic [PCNT_W-1:0] j_reg, j_next;
    logic              iss_reg, iss_next;
    logic              ov_reg, ov_next;
    logic [63:0]       sum_reg, sum_next;
    logic [63:0]       x_reg, x_next;
    logic [63:0]       y_reg, y_next;
    logic [63:0]       hi_reg, hi_next;
    logic [63:0]       t_reg, t_next;
    logic [63:0]       v_reg, v_next;
    logic              has_reg, has_next;
    logic              last_reg, last_next;

    logic [PCNT_W-1:0] jm1;
    logic              lt;
    logic              in_nan, in_inf;
    seq_state_t        after_merge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            mode_reg <= MODE_MZERO;
            cnt_reg  <= '0;
            iss_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            iss_reg  <= iss_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kept_reg <= kept_next;
        j_reg    <= j_next;
        sum_reg  <= sum_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        hi_reg   <= hi_next;
        t_reg    <= t_next;
        v_reg    <= v_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        kept_next = kept_reg;
        j_next    = j_reg;
        iss_next  = iss_reg;
        ov_next   = ov_reg;
        sum_next  = sum_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        hi_next   = hi_reg;
        t_next    = t_reg;
        v_next    = v_reg;
        has_next  = has_reg;
        last_next = last_reg;

        in_ready  = 1'b0;
        add_start = 1'b0;
        add_req   = '{a: x_reg, b: y_reg, sub: 1'b0};
        ram_we    = 1'b0;
        ram_waddr = kept_reg[PIDX_W-1:0];
        ram_wdata = add_res;
        ram_raddr = j_reg[PIDX_W-1:0];

        jm1         = j_reg - PCNT_W'(1);
        lt          = !is_nan(x_reg) && !is_nan(ram_rdata) && (x_reg[62:0] < ram_rdata[62:0]);
        in_nan      = is_nan(v_reg);
        in_inf      = is_inf(v_reg);
        after_merge = last_reg ? S_FIN : S_IDLE;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    v_next    = value_bits;
                    has_next  = has_value;
                    last_next = is_last;
                    st_next   = S_TAKE;
                end
            end
            S_TAKE:
            begin
                st_next = after_merge;
                if (has_reg)
                begin
                    case (mode_reg)
                        MODE_MZERO, MODE_FINITE, MODE_PINF, MODE_MINF:
                        begin
                            if (in_nan)
                            begin
                                mode_next = MODE_NAN;
                            end
                            else if (in_inf)
                            begin
                                if (!v_reg[63])
                                begin
                                    mode_next = (mode_reg == MODE_MINF) ? MODE_NAN : MODE_PINF;
                                end
                                else
                                begin
                                    mode_next = (mode_reg == MODE_PINF) ? MODE_NAN : MODE_MINF;
                                end
                            end
                            else if ((mode_reg == MODE_PINF) || (mode_reg == MODE_MINF))
                            begin
                                mode_next = mode_reg;
                            end
                            else if (is_zero(v_reg))
                            begin
                                if (!v_reg[63])
                                begin
                                    mode_next = MODE_FINITE;
                                end
                            end
                            else
                            begin
                                mode_next = MODE_FINITE;
                                x_next    = v_reg;
                                j_next    = '0;
                                kept_next = '0;
                                st_next   = S_RD;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                st_next = (j_reg == cnt_reg) ? S_TAIL : S_LD;
            end
            S_LD:
            begin
                // larger magnitude goes to x
                x_next  = lt ? ram_rdata : x_reg;
                y_next  = lt ? x_reg : ram_rdata;
                st_next = S_HI;
            end
            S_HI:
            begin
                add_req   = '{a: x_reg, b: y_reg, sub: 1'b0};
                add_start = !iss_reg;
                iss_next  = 1'b1;
                if (add_done)
                begin
                    hi_next  = add_res;
                    iss_next = 1'b0;
                    st_next  = S_T;
                end
            end
            S_T:
            begin
                add_req   = '{a: hi_reg, b: x_reg, sub: 1'b1};
                add_start = !iss_reg;
                iss_next  = 1'b1;
                if (add_done)
                begin
                    t_next   = add_res;
                    iss_next = 1'b0;
                    st_next  = S_LO;
                end
            end
            S_LO:
            begin
                add_req   = '{a: y_reg, b: t_reg, sub: 1'b1};
                add_start = !iss_reg;
                iss_next  = 1'b1;
                if (add_done)
                begin
                    iss_next = 1'b0;
                    if (add_res[62:0] != 63'd0)
                    begin
                        ram_we    = 1'b1;
                        kept_next = kept_reg + PCNT_W'(1);
                    end
                    x_next  = hi_reg;
                    j_next  = j_reg + PCNT_W'(1);
                    st_next = S_RD;
                end
            end
            S_TAIL:
            begin
                ram_raddr = PIDX_W'(MAX_PARTIALS - 1);
                if (kept_reg < MAX_CNT)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = x_reg;
                    cnt_next  = kept_reg + PCNT_W'(1);
                    st_next   = after_merge;
                end
                else
                begin
                    st_next = S_TLD;
                end
            end
            S_TLD:
            begin
                y_next  = ram_rdata;
                st_next = S_TADD;
            end
            S_TADD:
            begin
                // store full: fold the top value into the last entry
                add_req   = '{a: y_reg, b: x_reg, sub: 1'b0};
                add_start = !iss_reg;
                iss_next  = 1'b1;
                ram_waddr = PIDX_W'(MAX_PARTIALS - 1);
                if (add_done)
                begin
                    iss_next = 1'b0;
                    ram_we   = 1'b1;
                    cnt_next = MAX_CNT;
                    st_next  = after_merge;
                end
            end
            S_FIN:
            begin
                st_next = S_EMIT;
                case (mode_reg)
                    MODE_MZERO:
                    begin
                        hi_next = MZERO_BITS;
                    end
                    MODE_FINITE:
                    begin
                        j_next  = cnt_reg;
                        x_next  = PZERO_BITS;
                        st_next = S_FRD;
                    end
                    MODE_PINF:
                    begin
                        hi_next = PINF_BITS;
                    end
                    MODE_MINF:
                    begin
                        hi_next = MINF_BITS;
                    end
                    default:
                    begin
                        hi_next = QNAN_BITS;
                    end
                endcase
            end
            S_FRD:
            begin
                ram_raddr = jm1[PIDX_W-1:0];
                if (j_reg == '0)
                begin
                    hi_next = x_reg;
                    st_next = S_EMIT;
                end
                else
                begin
                    st_next = S_FLD;
                end
            end
            S_FLD:
            begin
                y_next  = ram_rdata;
                st_next = S_FADD;
            end
            S_FADD:
            begin
                add_req   = '{a: x_reg, b: y_reg, sub: 1'b0};
                add_start = !iss_reg;
                iss_next  = 1'b1;
                if (add_done)
                begin
                    iss_next = 1'b0;
                    x_next   = add_res;
                    j_next   = jm1;
                    st_next  = S_FRD;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    sum_next  = hi_reg;
                    ov_next   = 1'b1;
                    mode_next = MODE_MZERO;
                    cnt_next  = '0;
                    st_next   = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign sum_bits  = sum_reg;
    assign stat      = '{idle: (st_reg == S_IDLE), cnt: cnt_reg};

endmodule

// ===== sim/exact_double_stream_sum_top_tb.sv =====
// Testbench for exact_double_stream_sum_top: random and directed binary64 lists,
// with expected sums worked out from a partial-sum model built on real arithmetic.
// Depends on eds_pkg and the top level; no files read.
`timescale 1ns / 1ps

module exact_double_stream_sum_top_tb;
    import eds_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic [63:0] bits;
        logic        has;
        logic        last;
    } elem_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] value_bits;
    logic        has_value;
    logic        is_last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] sum_bits;

    exact_double_stream_sum_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value_bits(value_bits),
        .has_value (has_value),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_bits  (sum_bits)
    );

    elem_beat_t  pending_beats[$];
    logic [63:0] expected_sums[$];
    real         partials[$];
    mode_t       list_mode;
    int          mismatches;
    int          idle_cycles;
    int          beats_taken;
    int          in_gap;
    int          out_gap;
    int          hold_cycles;
    bit          hold_done;
    bit          in_fire;
    bit          out_fire;
    logic [63:0] recent_vals[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic real fabs_r(input real a);
        return (a < 0.0) ? -a : a;
    endfunction

    function automatic void merge_partial(input real xin);
        real x;
        real y;
        real t;
        real hi;
        real lo;
        real kept[$];
        x = xin;
        foreach (partials[j])
        begin
            y = partials[j];
            if (fabs_r(x) < fabs_r(y))
            begin
                t = x;
                x = y;
                y = t;
            end
            hi = x + y;
            lo = y - (hi - x);
            if (lo != 0.0)
                kept.insert(kept.size(), lo);
            x = hi;
        end
        if (kept.size() < MAX_PARTIALS)
            kept.insert(kept.size(), x);
        else
            kept[MAX_PARTIALS-1] = kept[MAX_PARTIALS-1] + x;
        partials = kept;
    endfunction

    function automatic void absorb_element(input logic [63:0] b);
        logic is_nan_v;
        logic is_inf_v;
        is_nan_v = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        is_inf_v = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
        if (list_mode == MODE_NAN)
            return;
        if (is_nan_v)
        begin
            list_mode = MODE_NAN;
            return;
        end
        if (is_inf_v)
        begin
            if (!b[63])
                list_mode = (list_mode == MODE_MINF) ? MODE_NAN : MODE_PINF;
            else
                list_mode = (list_mode == MODE_PINF) ? MODE_NAN : MODE_MINF;
            return;
        end
        if (list_mode == MODE_PINF || list_mode == MODE_MINF)
            return;
        if (b[62:0] == 63'd0)
        begin
            if (!b[63] && list_mode == MODE_MZERO)
                list_mode = MODE_FINITE;
            return;
        end
        list_mode = MODE_FINITE;
        merge_partial($bitstoreal(b));
    endfunction

    function automatic logic [63:0] list_total();
        real total;
        case (list_mode)
            MODE_MZERO:  return MZERO_BITS;
            MODE_FINITE: ;
            MODE_PINF:   return PINF_BITS;
            MODE_MINF:   return MINF_BITS;
            default:     return QNAN_BITS;
        endcase
        total = 0.0;
        for (int n = partials.size() - 1; n >= 0; n--)
            total = total + partials[n];
        return $realtobits(total);
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void add_beat(input logic [63:0] b, input logic h, input logic l);
        elem_beat_t e;
        e.bits = b;
        e.has  = h;
        e.last = l;
        pending_beats.insert(pending_beats.size(), e);
    endfunction

    function automatic void add_list(input logic [63:0] vals[$]);
        foreach (vals[i])
            add_beat(vals[i], 1'b1, i == vals.size() - 1);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            v = {$urandom, $urandom};
        else if (pick < 75)
            v = {1'($urandom), 11'(1023 - 30 + $urandom_range(0, 60)),
                 20'($urandom), $urandom};
        else if (pick < 85 && recent_vals.size() > 0)
        begin
            // negated earlier value to force cancellation
            v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
            v[63] = ~v[63];
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: v = PZERO_BITS;
                1: v = MZERO_BITS;
                2: v = $urandom_range(0, 1) ? PINF_BITS : MINF_BITS;
                3: v = {1'($urandom), 11'h7FF, 20'($urandom) | 20'h1, $urandom};
                4: v = {1'($urandom), 11'h000, 20'($urandom), $urandom};
                default: v = {1'($urandom), 11'h7FE, 20'($urandom), $urandom};
            endcase
        end
        recent_vals.insert(recent_vals.size(), v);
        if (recent_vals.size() > 16)
            void'(recent_vals.pop_front());
        return v;
    endfunction

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                elem_beat_t e;
                e = pending_beats.pop_front();
                value_bits <= e.bits;
                has_value  <= e.has;
                is_last    <= e.last;
                in_valid   <= 1'b1;
                // every fourth stretch of 40 beats runs back to back
                in_gap <= ((beats_taken / 40) % 4 == 1) ? 0 : $urandom_range(0, 4);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver; one long hold-off once the run is under way
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && beats_taken >= 150)
            begin
                hold_done   <= 1'b1;
                hold_cycles <= 600;
                out_ready   <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready   <= 1'b0;
            end
            else if (out_fire)
            begin
                out_gap   <= ((beats_taken / 40) % 4 == 2) ? 0 : $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------- monitor and watchdog ----------------
    always @(posedge clk)
    begin
        logic [63:0] exp_sum;
        in_fire  = in_valid && in_ready;
        out_fire = out_valid && out_ready;
        if (in_fire)
        begin
            beats_taken++;
            if (has_value)
                absorb_element(value_bits);
            if (is_last)
            begin
                expected_sums.insert(expected_sums.size(), list_total());
                list_mode = MODE_MZERO;
                partials.delete();
            end
        end
        if (out_fire)
        begin
            if (expected_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sum beat: sum_bits=%h", sum_bits);
            end
            else
            begin
                exp_sum = expected_sums.pop_front();
                if (sum_bits !== exp_sum)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sum_bits mismatch: expected %h actual %h", exp_sum, sum_bits);
                end
            end
        end
        if (in_fire || out_fire)
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        logic [63:0] vals[$];
        int len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        value_bits  = '0;
        has_value   = 1'b0;
        is_last     = 1'b0;
        out_ready   = 1'b0;
        in_gap      = 0;
        out_gap     = 0;
        hold_cycles = 0;
        hold_done   = 1'b0;
        in_fire     = 1'b0;
        out_fire    = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        beats_taken = 0;
        list_mode   = MODE_MZERO;

        // empty list, zeros, infinities, NaN, overflow, cancellation, subnormals
        add_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
        add_list('{PZERO_BITS});
        add_list('{MZERO_BITS, MZERO_BITS});
        add_list('{64'h3FF0_0000_0000_0000, PINF_BITS, 64'h4000_0000_0000_0000});
        add_list('{MINF_BITS, PINF_BITS, 64'h3FF0_0000_0000_0000});
        add_list('{64'h7FF0_0000_0000_0001, MINF_BITS, 64'h3FF0_0000_0000_0000});
        add_list('{64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF});
        add_list('{64'h54B2_49AD_2594_C37D, 64'h3FF0_0000_0000_0000,
                   64'hD4B2_49AD_2594_C37D});
        add_list('{64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
                   64'h3CB0_0000_0000_0000});
        add_beat(64'h3FF0_0000_0000_0000, 1'b1, 1'b0);
        add_beat(64'h0000_0000_0000_0000, 1'b0, 1'b0);
        add_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);

        // random lists
        while (pending_beats.size() < 545)
        begin
            len = $urandom_range(0, 9);
            if (len == 0)
                add_beat({$urandom, $urandom}, 1'b0, 1'b1);
            else
            begin
                vals.delete();
                for (int i = 0; i < len; i++)
                    vals.insert(vals.size(), random_value());
                foreach (vals[i])
                begin
                    if ($urandom_range(0, 15) == 0)
                        add_beat({$urandom, $urandom}, 1'b0, 1'b0);
                    add_beat(vals[i], 1'b1, i == len - 1);
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() > 0 || in_valid || expected_sums.size() > 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/eds_pkg.sv
rtl/core/eds_ram.sv
rtl/core/eds_dadd.sv
rtl/core/eds_seq.sv
rtl/core/exact_double_stream_sum_top.sv
sim/exact_double_stream_sum_top_tb.sv
